/* rtl/btlpm_pkg.sv */
// shared types, codes and constants of the trie longest prefix match engine
`default_nettype none

package btlpm_pkg;

   // default sizing of the node pool and route index
   localparam int NODE_COUNT_DEF       = 4096;
   localparam int ROUTE_INDEX_BITS_DEF = 16;
   localparam int NODE_WIDTH_DEF       = 2 * $clog2(NODE_COUNT_DEF) + 1 + ROUTE_INDEX_BITS_DEF;

   // fixed field widths
   localparam int ADDR_BITS    = 32;
   localparam int TOP_BIT      = 31;
   localparam int INDEX_BITS   = 16;
   localparam int LEVEL_BITS   = 6;
   localparam int REQ_DATA_W   = 80;
   localparam int RSP_DATA_W   = 24;
   localparam int RSP_PAD_W    = RSP_DATA_W - 2 - INDEX_BITS;

   // request kinds
   localparam logic REQ_INSERT = 1'b0;
   localparam logic REQ_LOOKUP = 1'b1;

   // insert status codes
   localparam logic STATUS_OK   = 1'b0;
   localparam logic STATUS_FULL = 1'b1;

   // sequencer states
   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_STEP = 3'b010,
      ST_EMIT = 3'b100
   } btlpm_state_type;

   // one request beat
   typedef struct packed {
      logic                   req_type;
      logic [ADDR_BITS-1:0]   address;
      logic [ADDR_BITS-1:0]   route_mask;
      logic [INDEX_BITS-1:0]  route_index;
   } btlpm_req_type;

   // one result beat
   typedef struct packed {
      logic                   found;
      logic [INDEX_BITS-1:0]  match_index;
      logic                   status;
   } btlpm_rsp_type;

endpackage

`default_nettype wire

/* rtl/btlpm_ram.sv */
// generic single write port ram with registered read
`default_nettype none

module btlpm_ram
   import btlpm_pkg::*;
#(
   parameter int WIDTH = NODE_WIDTH_DEF,
   parameter int DEPTH = NODE_COUNT_DEF,
   localparam int AddrW = $clog2(DEPTH)
) (
   input  wire logic              clock,
   input  wire logic              wr_en,
   input  wire logic [AddrW-1:0]  wr_addr,
   input  wire logic [WIDTH-1:0]  wr_data,
   input  wire logic [AddrW-1:0]  rd_addr,
   output logic      [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

/* rtl/btlpm_walk.sv */
// trie walk sequencer: one node per cycle through the read port of the node memory
`default_nettype none

module btlpm_walk
   import btlpm_pkg::*;
#(
   parameter int NODE_COUNT       = NODE_COUNT_DEF,
   parameter int ROUTE_INDEX_BITS = ROUTE_INDEX_BITS_DEF,
   localparam int LinkW  = $clog2(NODE_COUNT),
   localparam int CountW = $clog2(NODE_COUNT + 1),
   localparam int NodeW  = 2 * LinkW + 1 + ROUTE_INDEX_BITS
) (
   input  wire logic              clock,
   input  wire logic              reset,
   // request side
   input  wire logic              req_valid,
   output logic                   req_ready,
   input  wire btlpm_req_type     req,
   // result side
   output logic                   res_valid,
   input  wire logic              res_ready,
   output btlpm_rsp_type          res,
   // node memory
   output logic                   ram_wr_en,
   output logic      [LinkW-1:0]  ram_wr_addr,
   output logic      [NodeW-1:0]  ram_wr_data,
   output logic      [LinkW-1:0]  ram_rd_addr,
   input  wire logic [NodeW-1:0]  ram_rd_data
);

   localparam int ValidPos = 2 * LinkW;

   btlpm_state_type              state_ff, state_in;
   logic [ADDR_BITS-1:0]         addr_ff, addr_in;
   logic [ADDR_BITS-1:0]         mask_ff, mask_in;
   logic                         lookup_ff, lookup_in;
   logic [ROUTE_INDEX_BITS-1:0]  idx_ff, idx_in;
   logic [LEVEL_BITS-1:0]        cnt_ff, cnt_in;
   logic [LinkW-1:0]             cur_addr_ff, cur_addr_in;
   logic [NodeW-1:0]             cur_ff, cur_in;
   logic                         fetched_ff, fetched_in;
   logic                         hit_ff, hit_in;
   logic [ROUTE_INDEX_BITS-1:0]  best_ff, best_in;
   logic [CountW-1:0]            used_ff, used_in;
   logic                         root_init_ff, root_init_in;
   btlpm_rsp_type                res_ff, res_in;

   logic [NodeW-1:0]             node_q;
   logic [LinkW-1:0]             kid0, kid1, child, new_idx;
   logic                         child_bit, child_ok, node_valid, at_bottom, pool_full;
   logic [ROUTE_INDEX_BITS-1:0]  node_route, lk_best;
   logic                         lk_hit;
   logic [NodeW-1:0]             link_node, route_node;

   // current node: fresh read (a root never written reads as zero), or the register copy of a just allocated node
   always_comb begin
      if (fetched_ff) begin
         if ((cur_addr_ff == '0) && !root_init_ff) begin
            node_q = '0;
         end else begin
            node_q = ram_rd_data;
         end
      end else begin
         node_q = cur_ff;
      end
   end

   // field decode and per-level decisions
   always_comb begin
      kid0       = node_q[LinkW-1:0];
      kid1       = node_q[2*LinkW-1:LinkW];
      node_valid = node_q[ValidPos];
      node_route = node_q[NodeW-1:ValidPos+1];
      child_bit  = addr_ff[TOP_BIT];
      child      = child_bit ? kid1 : kid0;
      child_ok   = (child != '0);
      at_bottom  = (cnt_ff == LEVEL_BITS'(ADDR_BITS));
      pool_full  = (used_ff >= CountW'(NODE_COUNT));
      new_idx    = used_ff[LinkW-1:0];
      lk_hit     = hit_ff | node_valid;
      lk_best    = node_valid ? node_route : best_ff;

      link_node = node_q;
      if (child_bit) begin
         link_node[2*LinkW-1:LinkW] = new_idx;
      end else begin
         link_node[LinkW-1:0] = new_idx;
      end

      route_node                     = node_q;
      route_node[ValidPos]           = 1'b1;
      route_node[NodeW-1:ValidPos+1] = idx_ff;
   end

   // sequencer
   always_comb begin
      state_in    = state_ff;
      addr_in     = addr_ff;
      mask_in     = mask_ff;
      lookup_in   = lookup_ff;
      idx_in      = idx_ff;
      cnt_in      = cnt_ff;
      cur_addr_in = cur_addr_ff;
      cur_in      = cur_ff;
      fetched_in  = fetched_ff;
      hit_in      = hit_ff;
      best_in     = best_ff;
      used_in     = used_ff;
      res_in      = res_ff;
      ram_rd_addr = child;
      ram_wr_en   = 1'b0;
      ram_wr_addr = cur_addr_ff;
      ram_wr_data = node_q;

      case (state_ff)
         ST_IDLE: begin
            ram_rd_addr = '0;
            if (req_valid) begin
               addr_in     = req.address;
               mask_in     = req.route_mask;
               lookup_in   = (req.req_type == REQ_LOOKUP);
               idx_in      = ROUTE_INDEX_BITS'(req.route_index);
               cnt_in      = '0;
               cur_addr_in = '0;
               fetched_in  = 1'b1;
               hit_in      = 1'b0;
               best_in     = '0;
               state_in    = ST_STEP;
            end
         end
         ST_STEP: begin
            if (lookup_ff) begin
               // lookup: remember the deepest route, stop at a missing child or at the last level
               hit_in  = lk_hit;
               best_in = lk_best;
               if (at_bottom || !child_ok) begin
                  res_in.found       = lk_hit;
                  res_in.match_index = INDEX_BITS'(lk_best);
                  res_in.status      = STATUS_OK;
                  state_in           = ST_EMIT;
               end else begin
                  cur_addr_in = child;
                  fetched_in  = 1'b1;
                  cnt_in      = cnt_ff + 1'b1;
                  addr_in     = addr_ff << 1;
                  mask_in     = mask_ff << 1;
               end
            end else if (!mask_ff[TOP_BIT]) begin
               // insert reached prefix depth: attach the route
               ram_wr_en          = 1'b1;
               ram_wr_data        = route_node;
               res_in.found       = 1'b0;
               res_in.match_index = '0;
               res_in.status      = STATUS_OK;
               state_in           = ST_EMIT;
            end else if (child_ok) begin
               cur_addr_in = child;
               fetched_in  = 1'b1;
               cnt_in      = cnt_ff + 1'b1;
               addr_in     = addr_ff << 1;
               mask_in     = mask_ff << 1;
            end else if (pool_full) begin
               // pool exhausted: flush the current node so a fresh one reads cleared
               ram_wr_en          = 1'b1;
               ram_wr_data        = node_q;
               res_in.found       = 1'b0;
               res_in.match_index = '0;
               res_in.status      = STATUS_FULL;
               state_in           = ST_EMIT;
            end else begin
               // allocate a child and link it; the new node lives in cur_ff
               ram_wr_en   = 1'b1;
               ram_wr_data = link_node;
               cur_addr_in = new_idx;
               cur_in      = '0;
               fetched_in  = 1'b0;
               used_in     = used_ff + 1'b1;
               cnt_in      = cnt_ff + 1'b1;
               addr_in     = addr_ff << 1;
               mask_in     = mask_ff << 1;
            end
         end
         ST_EMIT: begin
            if (res_ready) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      root_init_in = root_init_ff | (ram_wr_en && (ram_wr_addr == '0));
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         used_ff      <= CountW'(1);
         root_init_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         used_ff      <= used_in;
         root_init_ff <= root_init_in;
      end
   end

   // walk payload registers
   always_ff @(posedge clock) begin
      addr_ff     <= addr_in;
      mask_ff     <= mask_in;
      lookup_ff   <= lookup_in;
      idx_ff      <= idx_in;
      cnt_ff      <= cnt_in;
      cur_addr_ff <= cur_addr_in;
      cur_ff      <= cur_in;
      fetched_ff  <= fetched_in;
      hit_ff      <= hit_in;
      best_ff     <= best_in;
      res_ff      <= res_in;
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign res_valid = (state_ff == ST_EMIT);
   assign res       = res_ff;

endmodule

`default_nettype wire

/* rtl/binary_trie_longest_prefix_match.sv */
// IPv4 longest prefix match engine on a one-bit trie: top level with stream ports
//
// Requests arrive on the req_ stream: tuser selects insert (0) or lookup (1),
// tdata carries the address, the netmask and the route index. Each request
// gives exactly one beat on the rsp_ stream, in order: found, match_index and
// status. The block takes one request at a time.
// A request walks the trie one level per cycle through the single read port
// of the node memory: an accept step, one step per trie level visited
// (root plus up to 32 levels), and a step to hand the result to the output
// register. An insert walks the same way; allocating a node adds no step
// beyond the one of its own level.
// After reset the trie holds only an empty root and the pool count is one;
// no clearing pass runs, since nodes are cleared as they are allocated.
// A finished result waits in the output register while the receiver stalls;
// the next request is already accepted and walked meanwhile, and only its
// own result waits for the register to drain.
`default_nettype none

module binary_trie_longest_prefix_match
   import btlpm_pkg::*;
#(
   parameter int NODE_COUNT       = NODE_COUNT_DEF,
   parameter int ROUTE_INDEX_BITS = ROUTE_INDEX_BITS_DEF
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   // request stream
   input  wire logic                   req_tvalid,
   output logic                        req_tready,
   input  wire logic [REQ_DATA_W-1:0]  req_tdata,  // address, route_mask, route_index
   input  wire logic                   req_tuser,  // req_type
   // result stream
   output logic                        rsp_tvalid,
   input  wire logic                   rsp_tready,
   output logic      [RSP_DATA_W-1:0]  rsp_tdata   // found, match_index, status, zero pad
);

   localparam int LinkW = $clog2(NODE_COUNT);
   localparam int NodeW = 2 * LinkW + 1 + ROUTE_INDEX_BITS;

   btlpm_req_type     req;
   btlpm_rsp_type     res;
   logic              res_valid, res_ready;
   logic              ram_wr_en;
   logic [LinkW-1:0]  ram_wr_addr, ram_rd_addr;
   logic [NodeW-1:0]  ram_wr_data, ram_rd_data;
   logic              rsp_valid_ff, rsp_valid_in;
   btlpm_rsp_type     rsp_ff, rsp_in;

   // unpack the request beat
   always_comb begin
      req.req_type    = req_tuser;
      req.address     = req_tdata[ADDR_BITS-1:0];
      req.route_mask  = req_tdata[2*ADDR_BITS-1:ADDR_BITS];
      req.route_index = req_tdata[2*ADDR_BITS+INDEX_BITS-1:2*ADDR_BITS];
   end

   btlpm_walk #(
      .NODE_COUNT       (NODE_COUNT),
      .ROUTE_INDEX_BITS (ROUTE_INDEX_BITS)
   ) u_walk (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_tvalid),
      .req_ready   (req_tready),
      .req         (req),
      .res_valid   (res_valid),
      .res_ready   (res_ready),
      .res         (res),
      .ram_wr_en   (ram_wr_en),
      .ram_wr_addr (ram_wr_addr),
      .ram_wr_data (ram_wr_data),
      .ram_rd_addr (ram_rd_addr),
      .ram_rd_data (ram_rd_data)
   );

   btlpm_ram #(
      .WIDTH (NodeW),
      .DEPTH (NODE_COUNT)
   ) u_node_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   // output register: loads when empty or draining
   always_comb begin
      res_ready    = !rsp_valid_ff || rsp_tready;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_in       = rsp_ff;
      if (res_valid && res_ready) begin
         rsp_valid_in = 1'b1;
         rsp_in       = res;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   // pack the result beat
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{RSP_PAD_W{1'b0}}, rsp_ff.status, rsp_ff.match_index, rsp_ff.found};

endmodule

`default_nettype wire

/* verif/binary_trie_longest_prefix_match_test.sv */
// self-checking testbench of the trie longest prefix match engine
`timescale 1ns / 1ps

module binary_trie_longest_prefix_match_test;
   import btlpm_pkg::*;

   localparam int POOL_NODES = NODE_COUNT_DEF;
   localparam int LINK_W     = $clog2(NODE_COUNT_DEF);
   localparam logic [INDEX_BITS-1:0] IDX_MASK = INDEX_BITS'((1 << ROUTE_INDEX_BITS_DEF) - 1);
   localparam int RANDOM_ITEMS = 1080;
   localparam int DRAIN_CYCLES = 40;

   // route trie predictor and queue of expected result beats
   class trie_route_scoreboard;
      bit [LINK_W-1:0]     child [POOL_NODES][2];
      bit                  routed [POOL_NODES];
      bit [INDEX_BITS-1:0] route_id [POOL_NODES];
      int unsigned         nodes_used;
      btlpm_rsp_type       expected [$];
      int                  errors;
      int                  beats_seen;

      function new();
         nodes_used = 1;
         errors     = 0;
         beats_seen = 0;
      endfunction

      function void clear_node(int unsigned n);
         child[n][0] = '0;
         child[n][1] = '0;
         routed[n]   = 1'b0;
         route_id[n] = '0;
      endfunction

      function bit pool_full();
         return nodes_used >= POOL_NODES;
      endfunction

      function int pending();
         return expected.size();
      endfunction

      // walk the prefix while mask bits are set, growing the trie as needed
      function logic add_route(logic [ADDR_BITS-1:0] prefix, logic [ADDR_BITS-1:0] mask,
                               logic [INDEX_BITS-1:0] idx);
         int unsigned cur;
         int unsigned nxt;
         bit          dir;
         cur = 0;
         for (int b = TOP_BIT; b >= 0; b--) begin
            if (!mask[b]) break;
            dir = prefix[b];
            nxt = 32'(child[cur][dir]);
            if (nxt == 0) begin
               if (pool_full()) return STATUS_FULL;
               nxt = nodes_used;
               nodes_used++;
               clear_node(nxt);
               child[cur][dir] = LINK_W'(nxt);
            end
            cur = nxt;
         end
         routed[cur]   = 1'b1;
         route_id[cur] = idx & IDX_MASK;
         return STATUS_OK;
      endfunction

      // deepest route along the destination path, root included
      function btlpm_rsp_type best_route(logic [ADDR_BITS-1:0] dest);
         btlpm_rsp_type res;
         int unsigned   cur;
         int unsigned   nxt;
         cur             = 0;
         res.found       = routed[0];
         res.match_index = routed[0] ? route_id[0] : '0;
         res.status      = STATUS_OK;
         for (int b = TOP_BIT; b >= 0; b--) begin
            nxt = 32'(child[cur][dest[b]]);
            if (nxt == 0) break;
            cur = nxt;
            if (routed[cur]) begin
               res.found       = 1'b1;
               res.match_index = route_id[cur];
            end
         end
         return res;
      endfunction

      function void note_request(btlpm_req_type r);
         btlpm_rsp_type res;
         if (r.req_type == REQ_INSERT) begin
            res.found       = 1'b0;
            res.match_index = '0;
            res.status      = add_route(r.address, r.route_mask, r.route_index);
         end else begin
            res = best_route(r.address);
         end
         expected.push_back(res);
      endfunction

      task report(string what);
         $display("%0t ns: mismatch: %s", $time, what);
         errors++;
      endtask

      // compare one result beat with the oldest expectation
      task check_result(logic [RSP_DATA_W-1:0] beat);
         btlpm_rsp_type want;
         beats_seen++;
         if (expected.size() == 0) begin
            report($sformatf("result beat %0d %h with nothing expected", beats_seen, beat));
            return;
         end
         want = expected.pop_front();
         if (beat[0] !== want.found)
            report($sformatf("beat %0d found %b, want %b", beats_seen, beat[0], want.found));
         if (beat[16:1] !== want.match_index)
            report($sformatf("beat %0d match_index %h, want %h", beats_seen, beat[16:1],
                             want.match_index));
         if (beat[17] !== want.status)
            report($sformatf("beat %0d status %b, want %b", beats_seen, beat[17], want.status));
      endtask
   endclass

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;  // address, route_mask, route_index
   logic                  req_tuser = 1'b0; // req_type
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;       // found, match_index, status, zero pad

   trie_route_scoreboard sb = new();
   bit                   steady = 1'b0;
   logic [ADDR_BITS-1:0] known_prefix [$];
   logic [ADDR_BITS-1:0] base_addr [8];

   binary_trie_longest_prefix_match DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always #5 clock = ~clock;

   function automatic logic [ADDR_BITS-1:0] prefix_mask(int len);
      return {ADDR_BITS{1'b1}} << (ADDR_BITS - len);
   endfunction

   function automatic btlpm_req_type make_item(logic kind, logic [ADDR_BITS-1:0] addr,
                                               logic [ADDR_BITS-1:0] mask,
                                               logic [INDEX_BITS-1:0] idx);
      btlpm_req_type r;
      r.req_type    = kind;
      r.address     = addr;
      r.route_mask  = mask;
      r.route_index = idx;
      return r;
   endfunction

   // present one request beat after a random gap and wait for its acceptance
   task automatic send(btlpm_req_type r);
      int gap;
      gap = steady ? 0 : $urandom_range(0, 16);
      if (gap != 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= r.req_type;
      req_tdata  <= {r.route_index, r.route_mask, r.address};
      do @(posedge clock); while (!req_tready);
      sb.note_request(r);
      if (r.req_type == REQ_INSERT && r.route_mask[TOP_BIT])
         known_prefix.push_back(r.address);
   endtask

   // mostly routes clustered around a few bases and lookups near known prefixes
   task automatic random_item(output btlpm_req_type r);
      int                   pick;
      int                   len;
      logic [ADDR_BITS-1:0] addr;
      pick = $urandom_range(0, 99);
      if (pick < 42) begin
         len  = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 32) : $urandom_range(1, 24);
         addr = base_addr[$urandom_range(0, 7)] ^ ($urandom >> $urandom_range(8, 32));
         r    = make_item(REQ_INSERT, addr, prefix_mask(len), INDEX_BITS'($urandom));
      end else if (pick < 48) begin
         r = make_item(REQ_INSERT, $urandom, $urandom, INDEX_BITS'($urandom));
      end else if (pick < 52) begin
         r = make_item(REQ_INSERT, $urandom, {ADDR_BITS{1'b1}}, INDEX_BITS'($urandom));
      end else if (pick < 85 && known_prefix.size() != 0) begin
         addr = known_prefix[$urandom_range(0, known_prefix.size() - 1)];
         r    = make_item(REQ_LOOKUP, addr ^ ($urandom >> $urandom_range(0, 32)),
                          $urandom, INDEX_BITS'($urandom));
      end else begin
         r = make_item(REQ_LOOKUP, $urandom, $urandom, INDEX_BITS'($urandom));
      end
   endtask

   // result side: random stalls between accepted beats
   initial begin
      int stall;
      do @(posedge clock); while (reset);
      forever begin
         stall = steady ? 0 : $urandom_range(0, 16);
         if (stall != 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
      end
   end

   // result monitor
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) sb.check_result(rsp_tdata);
   end

   // stimulus
   initial begin
      btlpm_req_type r;
      for (int k = 0; k < 8; k++) base_addr[k] = $urandom;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // empty trie, then nested prefixes, default route, host routes, odd masks
      send(make_item(REQ_LOOKUP, 32'h0000_0000, 32'hffff_ffff, 16'hffff));
      send(make_item(REQ_LOOKUP, 32'hffff_ffff, 32'h0000_0000, 16'h0000));
      send(make_item(REQ_INSERT, 32'h0a00_0000, 32'hff00_0000, 16'h0005));
      send(make_item(REQ_LOOKUP, 32'h0a01_0203, 32'h0, 16'h0));
      send(make_item(REQ_LOOKUP, 32'h0b00_0000, 32'h0, 16'h0));
      send(make_item(REQ_INSERT, 32'h0a01_0000, 32'hffff_0000, 16'h0007));
      send(make_item(REQ_LOOKUP, 32'h0a01_0909, 32'h0, 16'h0));
      send(make_item(REQ_LOOKUP, 32'h0a00_0001, 32'h0, 16'h0));
      send(make_item(REQ_INSERT, 32'h1234_5678, 32'h0000_0000, 16'hffff));
      send(make_item(REQ_LOOKUP, 32'hc801_0101, 32'h0, 16'h0));
      send(make_item(REQ_INSERT, 32'hffff_ffff, 32'hffff_ffff, 16'haaaa));
      send(make_item(REQ_LOOKUP, 32'hffff_ffff, 32'h0, 16'h0));
      send(make_item(REQ_LOOKUP, 32'hffff_fffe, 32'h0, 16'h0));
      send(make_item(REQ_INSERT, 32'h0000_0000, 32'hffff_ffff, 16'h5555));
      send(make_item(REQ_LOOKUP, 32'h0000_0000, 32'h0, 16'h0));
      send(make_item(REQ_INSERT, 32'hc0a8_0101, 32'hff00_ff00, 16'h1234));
      send(make_item(REQ_LOOKUP, 32'hc000_0001, 32'h0, 16'h0));
      send(make_item(REQ_INSERT, 32'h0aff_ffff, 32'hff00_0000, 16'h0000));
      send(make_item(REQ_LOOKUP, 32'h0ac8_0000, 32'h0, 16'h0));
      send(make_item(REQ_INSERT, 32'h8000_0000, 32'h7fff_ffff, 16'h0001));
      send(make_item(REQ_LOOKUP, 32'h0102_0304, 32'h0, 16'h0));

      // random traffic, with stretches of back-to-back beats on both sides
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         if (n % 64 == 0) steady = ($urandom_range(0, 3) == 0);
         random_item(r);
         send(r);
      end
      steady = 1'b0;

      // host routes until the node pool runs out, then traffic on a full pool
      while (!sb.pool_full())
         send(make_item(REQ_INSERT, $urandom, {ADDR_BITS{1'b1}}, INDEX_BITS'($urandom)));
      for (int n = 0; n < 30; n++) begin
         random_item(r);
         send(r);
      end
      req_tvalid <= 1'b0;

      while (sb.pending() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (sb.errors == 0)
         $display("binary_trie_longest_prefix_match verification clean");
      else
         $display("binary_trie_longest_prefix_match verification failed");
      $finish;
   end

   // watchdog
   initial begin
      #10_000_000;
      $display("binary_trie_longest_prefix_match verification failed");
      $finish;
   end

endmodule

/* sim.f */
rtl/btlpm_pkg.sv
rtl/btlpm_ram.sv
rtl/btlpm_walk.sv
rtl/binary_trie_longest_prefix_match.sv
verif/binary_trie_longest_prefix_match_test.sv
